### design/selm_pkg.sv
// Shared types, codes and defaults for the shared/exclusive lock manager.
// No dependencies; selm_ctrl, selm_dp and the top level import this package.
package selm_pkg;

    localparam int NUM_KEYS_DEF    = 256;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_TXNS_DEF    = 64;

    localparam int OP_W     = 2;
    localparam int TXN_IN_W = 6;
    localparam int KEY_IN_W = 8;
    localparam int ENT_W    = TXN_IN_W + 1;   // exclusive flag over txn id
    localparam int WAIT_W   = 8;
    localparam int KIND_W   = 2;
    localparam int MODE_W   = 2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WLOCK   = 2'd0,
        OP_RLOCK   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_STATUS  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        K_REPLY = 2'd0,
        K_READY = 2'd1,
        K_OWNER = 2'd2
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        M_NONE   = 2'd0,
        M_SHARED = 2'd1,
        M_EXCL   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_CNT_RD,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_PR,
        S_DECIDE,
        S_G_RD,
        S_G_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic latch;
        logic reduce;
        logic rd_cnt;
        logic load;
        logic scan_pr;
        logic decide;
        logic g_rd;
        logic g_skip;
        logic g_wr;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic red_done;
        logic scan_done;
        logic g_done;
        logic g_elig;
    } t_sts;

    typedef struct packed {
        t_kind               kind;
        logic                granted;
        logic [TXN_IN_W-1:0] txn;
        logic                ov;
        t_mode               mode;
        logic                err;
    } t_res;

endpackage

### design/selm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module selm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

### design/selm_ctrl.sv
// Sequencer for the lock manager: one state per step of an operation.
// Depends on selm_pkg (state enum, command and status structs).
module selm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  selm_pkg::t_sts i_sts,
    output selm_pkg::t_cmd o_cmd,
    output logic          busy
);
    import selm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_sts.red_done) n_state = S_CNT_RD;
                else o_cmd.reduce = 1'b1;
            end
            S_CNT_RD: begin
                o_cmd.rd_cnt = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = i_sts.scan_done ? S_DECIDE : S_SCAN_PR;
            end
            S_SCAN_PR: begin
                o_cmd.scan_pr = 1'b1;
                n_state       = S_SCAN_RD;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_G_RD;
            end
            S_G_RD: begin
                o_cmd.g_rd = 1'b1;
                if (i_sts.g_done) n_state = S_FIN;
                else if (i_sts.g_elig) n_state = S_G_WR;
                else o_cmd.g_skip = 1'b1;
            end
            S_G_WR: begin
                o_cmd.g_wr = 1'b1;
                n_state    = S_G_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign busy = (r_state != S_IDLE);
endmodule

### design/selm_dp.sv
// Datapath for the lock manager: tables in RAM, queue walk, grant list,
// one-deep result hold for the last flag. Depends on selm_pkg, selm_ram.
module selm_dp #(
    parameter int NUM_KEYS    = selm_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = selm_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_TXNS    = selm_pkg::NUM_TXNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  selm_pkg::t_cmd                  i_cmd,
    input  logic [selm_pkg::OP_W-1:0]       i_op,
    input  logic [selm_pkg::TXN_IN_W-1:0]   i_txn_id,
    input  logic [selm_pkg::KEY_IN_W-1:0]   i_key_index,
    output selm_pkg::t_sts                  o_sts,
    output logic                            o_valid,
    output selm_pkg::t_res                  o_res,
    output logic                            o_last
);
    import selm_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W = $clog2(NUM_KEYS);
    localparam int TXN_W = $clog2(NUM_TXNS);
    localparam int QA_N  = NUM_KEYS * QUEUE_DEPTH;
    localparam int QA_W  = $clog2(QA_N);
    localparam int CLR_N = (NUM_KEYS > NUM_TXNS) ? NUM_KEYS : NUM_TXNS;
    localparam int CLR_W = $clog2(CLR_N);

    // operation registers
    t_op                 r_op;
    logic [TXN_IN_W-1:0] r_txn;
    logic [KEY_IN_W-1:0] r_key;
    logic [CNT_W-1:0]    r_cnt, r_i, r_k, r_nown, r_ncand, r_j;
    logic [WAIT_W-1:0]   r_wcnt;
    logic                r_any_x, r_old_run, r_new_run, r_head_x, r_head_match;
    logic                r_found, r_rel_x, r_grant_en;
    logic [TXN_IN_W-1:0] r_own_txn  [QUEUE_DEPTH];
    logic [TXN_IN_W-1:0] r_cand_txn [QUEUE_DEPTH];
    logic                r_cand_x   [QUEUE_DEPTH];
    logic                r_cand_own [QUEUE_DEPTH];
    logic [CLR_W-1:0]    r_clr;
    t_res                r_pend;
    logic                r_pend_v;
    t_res                r_out;
    logic                r_out_v, r_out_last;

    // RAM ports
    logic              q_we, c_we, w_we;
    logic [QA_W-1:0]   q_wa, q_ra;
    logic [ENT_W-1:0]  q_wd, q_rd;
    logic [KEY_W-1:0]  c_wa, w_key;
    logic [CNT_W-1:0]  c_wd, c_rd;
    logic [TXN_W-1:0]  w_wa, w_ra;
    logic [WAIT_W-1:0] w_wd, w_rd;

    logic [QA_W-1:0]     w_base;
    logic                e_x, first, own_push, hm, keep, hit_e, hit_r, cand_push;
    logic [TXN_IN_W-1:0] e_t, g_txn;
    logic                is_rel, is_lock, is_stat, ok, full;
    logic [IDX_W-1:0]    j_idx;
    logic                em_v;
    t_res                em;

    selm_ram #(.WIDTH(ENT_W), .DEPTH(QA_N)) u_queue (
        .i_clk(i_clk), .i_wr_en(q_we), .i_wr_addr(q_wa), .i_wr_data(q_wd),
        .i_rd_addr(q_ra), .o_rd_data(q_rd)
    );
    selm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_KEYS)) u_count (
        .i_clk(i_clk), .i_wr_en(c_we), .i_wr_addr(c_wa), .i_wr_data(c_wd),
        .i_rd_addr(w_key), .o_rd_data(c_rd)
    );
    selm_ram #(.WIDTH(WAIT_W), .DEPTH(NUM_TXNS)) u_wait (
        .i_clk(i_clk), .i_wr_en(w_we), .i_wr_addr(w_wa), .i_wr_data(w_wd),
        .i_rd_addr(w_ra), .o_rd_data(w_rd)
    );

    assign w_key  = KEY_W'(r_key);
    assign w_base = QA_W'(32'(w_key) * QUEUE_DEPTH);
    assign q_ra   = w_base + QA_W'(r_i);
    assign j_idx  = r_j[IDX_W-1:0];
    assign g_txn  = r_cand_txn[j_idx];
    assign w_ra   = i_cmd.g_rd ? TXN_W'(g_txn) : TXN_W'(r_txn);

    assign e_x      = q_rd[ENT_W-1];
    assign e_t      = q_rd[TXN_IN_W-1:0];
    assign first    = (r_i == '0);
    assign own_push = r_old_run & (~e_x | first);
    assign hm       = first ? (e_t == r_txn) : r_head_match;
    // head release drops only the head; otherwise every entry of the txn
    assign keep      = hm ? ~first : (e_t != r_txn);
    assign cand_push = keep & r_new_run & (~e_x | (r_k == '0));

    assign is_rel  = (r_op == OP_RELEASE);
    assign is_stat = (r_op == OP_STATUS);
    assign is_lock = (r_op == OP_WLOCK) || (r_op == OP_RLOCK);
    assign ok      = (r_op == OP_WLOCK) ? (r_cnt == '0) : ~r_any_x;
    assign full    = (r_cnt == CNT_W'(QUEUE_DEPTH));

    // owner lookup against the old shared run (or exclusive head)
    always_comb begin
        hit_e = 1'b0;
        hit_r = 1'b0;
        for (int m = 0; m < QUEUE_DEPTH; m++) begin
            if (CNT_W'(m) < r_nown) begin
                if (r_own_txn[m] == e_t)   hit_e = 1'b1;
                if (r_own_txn[m] == r_txn) hit_r = 1'b1;
            end
        end
    end

    always_comb begin
        q_we = 1'b0;
        q_wa = w_base + QA_W'(r_k);
        q_wd = q_rd;
        if (i_cmd.scan_pr && is_rel && keep) begin
            q_we = 1'b1;
        end
        if (i_cmd.decide && is_lock && !full) begin
            q_we = 1'b1;
            q_wa = w_base + QA_W'(r_cnt);
            q_wd = {(r_op == OP_WLOCK), r_txn};
        end

        c_we = 1'b0;
        c_wa = w_key;
        c_wd = '0;
        if (i_cmd.clr) begin
            c_we = (32'(r_clr) < NUM_KEYS);
            c_wa = KEY_W'(r_clr);
        end
        if (i_cmd.decide) begin
            if (is_lock && !full) begin
                c_we = 1'b1;
                c_wd = r_cnt + 1'b1;
            end else if (is_rel && r_cnt != '0 && r_head_match) begin
                c_we = 1'b1;
                c_wd = r_cnt - 1'b1;
            end else if (is_rel && r_cnt != '0 && r_found) begin
                c_we = 1'b1;
                c_wd = r_k;
            end
        end

        w_we = 1'b0;
        w_wa = TXN_W'(r_txn);
        w_wd = '0;
        if (i_cmd.clr) begin
            w_we = (32'(r_clr) < NUM_TXNS);
            w_wa = TXN_W'(r_clr);
        end
        if (i_cmd.decide) begin
            if (is_lock && !full && !ok && r_wcnt != WAIT_MAX) begin
                w_we = 1'b1;
                w_wd = r_wcnt + 1'b1;
            end else if (is_rel && r_cnt != '0 && !r_head_match && r_found
                         && (r_rel_x || !hit_r) && r_wcnt != '0) begin
                w_we = 1'b1;
                w_wd = r_wcnt - 1'b1;
            end
        end
        if (i_cmd.g_wr && w_rd != '0) begin
            w_we = 1'b1;
            w_wa = TXN_W'(g_txn);
            w_wd = w_rd - 1'b1;
        end

        em_v = 1'b0;
        em   = '{kind: K_REPLY, granted: 1'b0, txn: '0, ov: 1'b0,
                 mode: M_NONE, err: 1'b0};
        if (i_cmd.scan_pr && is_stat && own_push) begin
            em_v    = 1'b1;
            em.kind = K_OWNER;
            em.txn  = e_t;
            em.ov   = 1'b1;
            em.mode = e_x ? M_EXCL : M_SHARED;
        end
        if (i_cmd.decide && is_lock) begin
            em_v       = 1'b1;
            em.granted = ~full & ok;
            em.txn     = r_txn;
            em.err     = full;
        end
        if (i_cmd.decide && is_stat && r_cnt == '0) begin
            em_v    = 1'b1;
            em.kind = K_OWNER;
        end
        if (i_cmd.g_wr && w_rd == WAIT_W'(1)) begin
            em_v    = 1'b1;
            em.kind = K_READY;
            em.txn  = g_txn;
        end
    end

    assign o_sts.clr_done  = (r_clr == CLR_W'(CLR_N - 1));
    assign o_sts.red_done  = (32'(r_key) < NUM_KEYS) && (32'(r_txn) < NUM_TXNS);
    assign o_sts.scan_done = (r_i == r_cnt);
    assign o_sts.g_done    = (r_j == r_ncand);
    assign o_sts.g_elig    = r_grant_en &
        (r_head_match ? (r_cand_x[j_idx] | r_head_x)
                      : (~r_cand_x[j_idx] & r_rel_x & ~r_cand_own[j_idx]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_grant_en <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.latch) begin
                r_op  <= t_op'(i_op);
                r_txn <= i_txn_id;
                r_key <= i_key_index;
            end
            if (i_cmd.reduce) begin
                if (32'(r_key) >= NUM_KEYS) r_key <= r_key - KEY_IN_W'(NUM_KEYS);
                if (32'(r_txn) >= NUM_TXNS) r_txn <= r_txn - TXN_IN_W'(NUM_TXNS);
            end
            if (i_cmd.rd_cnt) begin
                r_i          <= '0;
                r_k          <= '0;
                r_j          <= '0;
                r_nown       <= '0;
                r_ncand      <= '0;
                r_any_x      <= 1'b0;
                r_old_run    <= 1'b1;
                r_new_run    <= 1'b1;
                r_head_x     <= 1'b0;
                r_head_match <= 1'b0;
                r_found      <= 1'b0;
                r_rel_x      <= 1'b0;
                r_grant_en   <= 1'b0;
            end
            if (i_cmd.load) begin
                r_cnt  <= c_rd;
                r_wcnt <= w_rd;
            end
            if (i_cmd.scan_pr) begin
                r_i       <= r_i + 1'b1;
                r_old_run <= r_old_run & ~e_x;
                r_any_x   <= r_any_x | e_x;
                if (first) begin
                    r_head_x     <= e_x;
                    r_head_match <= hm;
                end
                if (is_rel && !hm && e_t == r_txn) begin
                    r_found <= 1'b1;
                    r_rel_x <= e_x;
                end
                if (own_push) begin
                    r_own_txn[r_nown[IDX_W-1:0]] <= e_t;
                    r_nown <= r_nown + 1'b1;
                end
                if (is_rel && keep) begin
                    r_k <= r_k + 1'b1;
                    if (e_x) r_new_run <= 1'b0;
                    if (cand_push) begin
                        r_cand_txn[r_ncand[IDX_W-1:0]] <= e_t;
                        r_cand_x[r_ncand[IDX_W-1:0]]   <= e_x;
                        r_cand_own[r_ncand[IDX_W-1:0]] <= hit_e | own_push;
                        r_ncand <= r_ncand + 1'b1;
                    end
                end
            end
            if (i_cmd.decide) begin
                r_grant_en <= is_rel && (r_cnt != '0) && (r_head_match || r_found);
            end
            if (i_cmd.g_skip || i_cmd.g_wr) r_j <= r_j + 1'b1;
            // hold one result back so the last one can be flagged
            if (em_v) begin
                r_pend   <= em;
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out      <= r_pend;
                    r_out_v    <= 1'b1;
                    r_out_last <= 1'b0;
                end
            end
            if (i_cmd.fin && r_pend_v) begin
                r_out      <= r_pend;
                r_out_v    <= 1'b1;
                r_out_last <= 1'b1;
                r_pend_v   <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_out_last;
endmodule

### design/shared_exclusive_lock_manager.sv
// Shared/exclusive lock manager, top level. One operation at a time.
// Busy from the accepting edge through subtracts while key or txn is out of
// range, count read, load, a read and a process step per queued request of the
// key, decide, on release a read per grant candidate (and a write when it is
// handed the lock), and finish; the last word is strobed as busy falls. Reset:
// sync active low; then a clear pass over max(NUM_KEYS, NUM_TXNS) entries with
// busy high. Results are strobed for one cycle; the receiver cannot stall.
module shared_exclusive_lock_manager #(
    parameter int NUM_KEYS    = selm_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = selm_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_TXNS    = selm_pkg::NUM_TXNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [selm_pkg::OP_W-1:0]     i_op,
    input  logic [selm_pkg::TXN_IN_W-1:0] i_txn_id,
    input  logic [selm_pkg::KEY_IN_W-1:0] i_key_index,
    output logic                          o_valid,
    output logic [selm_pkg::KIND_W-1:0]   o_kind,
    output logic                          o_granted,
    output logic [selm_pkg::TXN_IN_W-1:0] o_out_txn,
    output logic                          o_owner_valid,
    output logic [selm_pkg::MODE_W-1:0]   o_mode,
    output logic                          o_error,
    output logic                          o_last
);
    import selm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_res res;

    // Controller walks the steps; datapath holds the tables and the
    // per-operation scratch (owner list, grant list).
    selm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start),
        .i_sts(sts), .o_cmd(cmd), .busy(busy)
    );

    selm_dp #(
        .NUM_KEYS(NUM_KEYS), .QUEUE_DEPTH(QUEUE_DEPTH), .NUM_TXNS(NUM_TXNS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_op(i_op), .i_txn_id(i_txn_id), .i_key_index(i_key_index),
        .o_sts(sts), .o_valid(o_valid), .o_res(res), .o_last(o_last)
    );

    // result word fields
    assign o_kind        = res.kind;
    assign o_granted     = res.granted;
    assign o_out_txn     = res.txn;
    assign o_owner_valid = res.ov;
    assign o_mode        = res.mode;
    assign o_error       = res.err;

    // an accepted word takes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the clear pass follows every reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("busy low right after reset");

    // a refused request is a lone lock reply
    a_error_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && o_kind == K_REPLY && !o_granted))
        else $error("refused request not a single lock reply");
endmodule

### dv/selm_checker.sv
`timescale 1ns / 1ps
// Lock-manager checker: watches accepted commands and result strobes, predicts.
// Depends on selm_pkg; the top bench instantiates it and makes its port hookup.
module selm_checker
    import selm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [TXN_IN_W-1:0]   i_txn_id,
    input  logic [KEY_IN_W-1:0]   i_key_index,
    input  logic                  i_valid,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic                  i_granted,
    input  logic [TXN_IN_W-1:0]   i_out_txn,
    input  logic                  i_owner_valid,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic                  i_error,
    input  logic                  i_last,
    output int                    o_errors,
    output int                    o_pending
);
    localparam int DEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                granted;
        logic [TXN_IN_W-1:0] txn;
        logic                ov;
        logic [MODE_W-1:0]   mode;
        logic                err;
        logic                last;
    } t_word;

    logic [ENT_W-1:0]  lock_q   [NUM_KEYS_DEF][DEPTH];
    int                lock_cnt [NUM_KEYS_DEF];
    logic [WAIT_W-1:0] waits    [NUM_TXNS_DEF];
    t_word             expected_words[$];
    t_word             batch[$];

    assign o_pending = expected_words.size();

    function automatic t_word mk(logic [KIND_W-1:0] k, logic g, logic [TXN_IN_W-1:0] t,
                                 logic ov, logic [MODE_W-1:0] m, logic e);
        t_word w;
        w = '{k, g, t, ov, m, e, 1'b0};
        return w;
    endfunction

    task automatic hand_over(logic [TXN_IN_W-1:0] t);
        if (waits[t] != 0) begin
            waits[t]--;
            if (waits[t] == 0) batch.insert(batch.size(), mk(K_READY, 0, t, 0, M_NONE, 0));
        end
    endtask

    function automatic bit owned(logic [ENT_W-1:0] q[DEPTH], int cnt, logic [TXN_IN_W-1:0] t);
        if (cnt == 0) return 0;
        if (q[0][ENT_W-1]) return q[0][TXN_IN_W-1:0] == t;
        for (int i = 0; i < cnt; i++) begin
            if (q[i][ENT_W-1]) return 0;
            if (q[i][TXN_IN_W-1:0] == t) return 1;
        end
        return 0;
    endfunction

    task automatic predict(logic [OP_W-1:0] op, logic [TXN_IN_W-1:0] t, logic [KEY_IN_W-1:0] k);
        int cnt;
        int n;
        bit ok;
        bit found;
        bit rel_x;
        bit prev_x;
        logic [ENT_W-1:0] old[DEPTH];
        cnt = lock_cnt[k];
        batch.delete();
        if (op == OP_WLOCK || op == OP_RLOCK) begin
            if (cnt >= DEPTH) batch.insert(batch.size(), mk(K_REPLY, 0, t, 0, M_NONE, 1));
            else begin
                ok = (op == OP_WLOCK) ? (cnt == 0) : 1'b1;
                if (op == OP_RLOCK)
                    for (int i = 0; i < cnt; i++) if (lock_q[k][i][ENT_W-1]) ok = 0;
                lock_q[k][cnt] = {op == OP_WLOCK, t};
                lock_cnt[k] = cnt + 1;
                if (!ok && waits[t] != WAIT_MAX) waits[t]++;
                batch.insert(batch.size(), mk(K_REPLY, ok, t, 0, M_NONE, 0));
            end
        end else if (op == OP_RELEASE) begin
            if (cnt == 0) return;
            if (lock_q[k][0][TXN_IN_W-1:0] == t) begin
                // head release: only the head entry goes
                prev_x = lock_q[k][0][ENT_W-1];
                for (int i = 0; i < cnt - 1; i++) lock_q[k][i] = lock_q[k][i+1];
                cnt--;
                lock_cnt[k] = cnt;
                if (cnt > 0) begin
                    if (lock_q[k][0][ENT_W-1]) hand_over(lock_q[k][0][TXN_IN_W-1:0]);
                    else if (prev_x)
                        for (int i = 0; i < cnt && !lock_q[k][i][ENT_W-1]; i++)
                            hand_over(lock_q[k][i][TXN_IN_W-1:0]);
                end
            end else begin
                // middle release: all entries of the txn go, last one decides
                old = lock_q[k];
                n = 0;
                found = 0;
                rel_x = 0;
                for (int i = 0; i < cnt; i++) begin
                    if (old[i][TXN_IN_W-1:0] == t) begin
                        found = 1;
                        rel_x = old[i][ENT_W-1];
                    end else begin
                        lock_q[k][n] = old[i];
                        n++;
                    end
                end
                if (!found) return;
                lock_cnt[k] = n;
                if (rel_x) begin
                    if (waits[t] != 0) waits[t]--;
                    for (int i = 0; i < n && !lock_q[k][i][ENT_W-1]; i++)
                        if (!owned(old, cnt, lock_q[k][i][TXN_IN_W-1:0]))
                            hand_over(lock_q[k][i][TXN_IN_W-1:0]);
                end else if (!owned(old, cnt, t)) begin
                    if (waits[t] != 0) waits[t]--;
                end
            end
        end else begin
            if (cnt == 0) batch.insert(batch.size(), mk(K_OWNER, 0, 0, 0, M_NONE, 0));
            else if (lock_q[k][0][ENT_W-1])
                batch.insert(batch.size(),
                             mk(K_OWNER, 0, lock_q[k][0][TXN_IN_W-1:0], 1, M_EXCL, 0));
            else
                for (int i = 0; i < cnt && !lock_q[k][i][ENT_W-1]; i++)
                    batch.insert(batch.size(),
                                 mk(K_OWNER, 0, lock_q[k][i][TXN_IN_W-1:0], 1, M_SHARED, 0));
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1;
        foreach (batch[i]) expected_words.insert(expected_words.size(), batch[i]);
    endtask

    task automatic compare_word();
        t_word e;
        if (expected_words.size() == 0) begin
            $error("unexpected result word kind=%0d txn=%0d", i_kind, i_out_txn);
            o_errors++;
            return;
        end
        e = expected_words[0];
        expected_words.delete(0);
        if (i_kind != e.kind) begin
            $error("kind exp %0d got %0d", e.kind, i_kind); o_errors++;
        end
        if (i_granted != e.granted) begin
            $error("granted exp %0d got %0d", e.granted, i_granted); o_errors++;
        end
        if (i_out_txn != e.txn) begin
            $error("out_txn exp %0d got %0d", e.txn, i_out_txn); o_errors++;
        end
        if (i_owner_valid != e.ov) begin
            $error("owner_valid exp %0d got %0d", e.ov, i_owner_valid); o_errors++;
        end
        if (i_mode != e.mode) begin
            $error("mode exp %0d got %0d", e.mode, i_mode); o_errors++;
        end
        if (i_error != e.err) begin
            $error("error exp %0d got %0d", e.err, i_error); o_errors++;
        end
        if (i_last != e.last) begin
            $error("last exp %0d got %0d", e.last, i_last); o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors = 0;
            foreach (lock_cnt[i]) lock_cnt[i] = 0;
            foreach (waits[i]) waits[i] = '0;
            expected_words.delete();
        end else begin
            // results first: a word on the strobe belongs to an earlier command
            if (i_valid) compare_word();
            if (i_start && !i_busy) predict(i_op, i_txn_id, i_key_index);
        end
    end
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top bench for the lock manager: clock, reset, command stimulus, verdict.
// Depends on selm_pkg, shared_exclusive_lock_manager and selm_checker.
module tb_top;
    import selm_pkg::*;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                start = 0;
    logic                busy;
    logic [OP_W-1:0]     i_op = '0;
    logic [TXN_IN_W-1:0] i_txn_id = '0;
    logic [KEY_IN_W-1:0] i_key_index = '0;
    logic                o_valid, o_granted, o_owner_valid, o_error, o_last;
    logic [KIND_W-1:0]   o_kind;
    logic [TXN_IN_W-1:0] o_out_txn;
    logic [MODE_W-1:0]   o_mode;
    int                  fail_count;
    int                  words_owed;

    always #4 i_clk = ~i_clk;

    shared_exclusive_lock_manager dut (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_txn_id, .i_key_index,
        .o_valid, .o_kind, .o_granted, .o_out_txn, .o_owner_valid, .o_mode,
        .o_error, .o_last
    );

    selm_checker chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_op, .i_txn_id,
        .i_key_index, .i_valid(o_valid), .i_kind(o_kind), .i_granted(o_granted),
        .i_out_txn(o_out_txn), .i_owner_valid(o_owner_valid), .i_mode(o_mode),
        .i_error(o_error), .i_last(o_last), .o_errors(fail_count),
        .o_pending(words_owed)
    );

    // Burst state for the sender: a run of back-to-back commands, then a gap.
    int burst_left = 0;

    // Issue one command word and hold start until the block takes it.
    // Start stays high through a burst; the block ignores it while busy.
    task automatic send_cmd(t_op op, logic [TXN_IN_W-1:0] t, logic [KEY_IN_W-1:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_txn_id    <= t;
        i_key_index <= k;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    initial begin
        t_op op;
        logic [TXN_IN_W-1:0] base_t;
        logic [KEY_IN_W-1:0] key;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty status, exclusive then shared waiters, hand-off.
        send_cmd(OP_STATUS, 6'd0, 8'd255);
        send_cmd(OP_WLOCK, 6'd63, 8'd255);
        send_cmd(OP_RLOCK, 6'd1, 8'd255);
        send_cmd(OP_RLOCK, 6'd2, 8'd255);
        send_cmd(OP_WLOCK, 6'd3, 8'd255);
        send_cmd(OP_STATUS, 6'd0, 8'd255);
        send_cmd(OP_RELEASE, 6'd5, 8'd255);     // absent txn: silent
        send_cmd(OP_RELEASE, 6'd63, 8'd255);    // head exclusive: shared run granted
        send_cmd(OP_STATUS, 6'd0, 8'd255);
        send_cmd(OP_RELEASE, 6'd2, 8'd255);     // middle shared owner
        send_cmd(OP_RELEASE, 6'd1, 8'd255);     // head shared: exclusive granted
        send_cmd(OP_STATUS, 6'd0, 8'd255);
        send_cmd(OP_RELEASE, 6'd3, 8'd255);
        send_cmd(OP_RELEASE, 6'd3, 8'd0);       // empty queue: silent
        // Fill key 0 past its depth to hit the queue-full refusal.
        for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++)
            send_cmd(i % 3 == 0 ? OP_WLOCK : OP_RLOCK, 6'(i), 8'd0);
        // Middle exclusive release, then drain key 0 from the head.
        send_cmd(OP_RELEASE, 6'd3, 8'd0);
        for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++) send_cmd(OP_RELEASE, 6'(i), 8'd0);

        // Random: mostly well-formed traffic on a few hot keys, some noise.
        for (int n = 0; n < 50; n++) begin
            key    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            base_t = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0, 1, 2: op = OP_RLOCK;
                3, 4:    op = OP_WLOCK;
                5, 6, 7: op = OP_RELEASE;
                default: op = OP_STATUS;
            endcase
            send_cmd(op, base_t, key);
        end
        start <= 1'b0;

        // Drain: wait for every owed word, then settle past the walk latency.
        while (words_owed != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && words_owed == 0)
            $display("[shared_exclusive_lock_manager] OK");
        else
            $display("[shared_exclusive_lock_manager] ERROR");
        $finish;
    end

    // Watchdog well past worst case: clear pass plus ~100 words of long walks.
    initial begin
        #2_000_000;
        $display("[shared_exclusive_lock_manager] ERROR");
        $finish;
    end
endmodule
